// ===== hw/rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg: shared types and codes for the periodic timer scheduler
// Action codes, controller states and the command/status structs that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package pts_pkg;

  // item actions
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ARM    = 2'd1,
    ACT_SYNC   = 2'd2,
    ACT_MODIFY = 2'd3
  } action_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIRE,
    ST_DIV,
    ST_ARM,
    ST_SYNC_MUL,
    ST_SYNC,
    ST_MODIFY,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_start; // clear the running minimum
    logic scan_step;  // compare one slot
    logic fire;       // apply firing to best slot
    logic div_start;  // start now % period
    logic div_step;   // one quotient bit
    logic arm;        // write the armed slot
    logic mul_step;   // sync threshold product
    logic sync;       // sync decision and write
    logic modify;     // modify write
    logic out_load;   // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic div_last;
    logic [1:0] action;
  } status_t;

  // time width in microseconds
  localparam int TIME_BITS = 48;
  localparam int RES_BITS  = 8;
  localparam int IN_BITS   = 2 + 4 + TIME_BITS * 5 + 16 + 1 + 9;
endpackage
`default_nettype wire

// ===== hw/rtl/pts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pts_ctrl: controller state machine of the periodic timer scheduler
// Sequences the slot scan, the restoring divider, the sync multiply and the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire pts_pkg::status_t  sts,
  output pts_pkg::cmd_t          cmd
);
  import pts_pkg::*;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        case (action_t'(sts.action))
          ACT_TICK:   state_nxt = ST_SCAN;
          ACT_ARM:    state_nxt = ST_DIV;
          ACT_SYNC:   state_nxt = ST_SYNC_MUL;
          default:    state_nxt = ST_MODIFY;
        endcase
        if (action_t'(sts.action) == ACT_TICK && sts.scan_last) state_nxt = ST_FIRE;
      end
      ST_FIRE:     state_nxt = ST_OUT;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_ARM;
      end
      ST_ARM:      state_nxt = ST_OUT;
      ST_SYNC_MUL: state_nxt = ST_SYNC;
      ST_SYNC:     state_nxt = ST_OUT;
      ST_MODIFY:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_tvalid || out_tready) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load       = in_tvalid;
        cmd.scan_start = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan_step = (action_t'(sts.action) == ACT_TICK);
        cmd.div_start = (action_t'(sts.action) == ACT_ARM);
      end
      ST_FIRE:     cmd.fire = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_ARM:      cmd.arm = 1'b1;
      ST_SYNC_MUL: cmd.mul_step = 1'b1;
      ST_SYNC:     cmd.sync = 1'b1;
      ST_MODIFY:   cmd.modify = 1'b1;
      ST_OUT:      cmd.out_load = !out_tvalid || out_tready;
      default: ;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  // state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pts_dp.sv =====
// ----------------------------------------------------------------------------
// pts_dp: datapath of the periodic timer scheduler
// Slot table, serial minimum scan, bit-serial divider for start alignment,
// sync threshold multiply and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_dp #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [pts_pkg::IN_BITS-1:0] in_item,
  input  wire pts_pkg::cmd_t            cmd,
  output pts_pkg::status_t              sts,
  output logic [pts_pkg::RES_BITS-1:0]  res_r
);
  import pts_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int DW = $clog2(TIME_BITS);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // captured item
  logic [1:0]           act_r;
  logic [3:0]           slot_r;
  logic [TIME_BITS-1:0] now_r, run_r, stop_r, per_r, off_r;
  logic [15:0]          lim_r;
  logic                 syn_r;
  logic [8:0]           marg_r;

  // slot table
  logic                 act_q   [TIMER_SLOTS];
  logic [TIME_BITS-1:0] due_q   [TIMER_SLOTS];
  logic [TIME_BITS-1:0] stopt_q [TIMER_SLOTS];
  logic [TIME_BITS-1:0] per_q   [TIMER_SLOTS];
  logic [15:0]          lim_q   [TIMER_SLOTS];
  logic [15:0]          cnt_q   [TIMER_SLOTS];
  logic [TIME_BITS-1:0] last_q  [TIMER_SLOTS];
  logic                 sen_q   [TIMER_SLOTS];

  // scan and divider state
  logic [SW:0]          scan_idx_r;
  logic [SW-1:0]        best_r;
  logic                 best_v_r;
  logic [TIME_BITS-1:0] best_due_r;
  logic [TIME_BITS:0]   rem_r;
  logic [DW:0]          div_cnt_r;
  logic [TIME_BITS+8:0] thr_r;

  logic          ok;
  logic [SW-1:0] sidx, cidx;
  assign ok   = ({5'd0, slot_r} < 9'(TIMER_SLOTS));
  assign sidx = SW'(slot_r);
  assign cidx = scan_idx_r[SW-1:0];

  assign sts.action    = act_r;
  assign sts.scan_last = (scan_idx_r == (SW+1)'(TIMER_SLOTS - 1));
  assign sts.div_last  = (div_cnt_r == '0);

  // fire arithmetic on best slot
  logic [TIME_BITS:0]   fsum;
  logic [15:0]          fcnt;
  logic                 fkeep, fdue;
  assign fsum = {1'b0, due_q[best_r]} + {1'b0, per_q[best_r]};
  assign fcnt = (cnt_q[best_r] == 16'hFFFF) ? cnt_q[best_r] : cnt_q[best_r] + 16'd1;
  assign fdue = best_v_r && (best_due_r <= now_r);
  assign fkeep = !fsum[TIME_BITS] && (per_q[best_r] != '0)
               && ((stopt_q[best_r] == '0) || (fsum[TIME_BITS-1:0] < stopt_q[best_r]))
               && ((lim_q[best_r] == '0) || (fcnt < lim_q[best_r]));

  // divider remainder step
  logic [TIME_BITS:0]   rem_sh, rem_sub;
  assign rem_sh  = {rem_r[TIME_BITS-1:0], now_r[div_cnt_r[DW-1:0]]};
  assign rem_sub = rem_sh - {1'b0, per_r};

  // arm start
  logic [TIME_BITS:0]   al_sum, st_sum;
  logic [TIME_BITS-1:0] aligned, base;
  assign al_sum  = {1'b0, now_r} + {1'b0, per_r - rem_r[TIME_BITS-1:0]};
  assign aligned = (rem_r == '0) ? now_r : (al_sum[TIME_BITS] ? TMAX : al_sum[TIME_BITS-1:0]);
  assign base    = ((per_r != '0) && (now_r >= run_r)) ? aligned : run_r;
  assign st_sum  = {1'b0, base} + {1'b0, off_r};

  // sync: late * 256 against period * margin
  logic [TIME_BITS-1:0] late;
  logic [TIME_BITS:0]   ns_sum;
  logic                 s_found, s_res;
  assign late    = now_r - last_q[sidx];
  assign ns_sum  = {1'b0, now_r} + {1'b0, per_q[sidx]};
  assign s_found = ok && act_q[sidx] && sen_q[sidx];
  assign s_res   = s_found && (now_r >= last_q[sidx])
                 && ({1'b0, late, 8'd0} > thr_r);

  // modify
  logic [TIME_BITS-1:0] m_due, m_stop, m_per;
  logic                 m_found;
  assign m_found = ok && act_q[sidx];
  assign m_due   = (run_r  != '0) ? run_r  : due_q[sidx];
  assign m_stop  = (stop_r != '0) ? stop_r : stopt_q[sidx];
  assign m_per   = (per_r  != '0) ? per_r  : per_q[sidx];

  // item capture, scan, divider, multiply
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {marg_r, syn_r, off_r, lim_r, per_r, stop_r, run_r, now_r, slot_r, act_r}
        <= in_item[9 + 1 + TIME_BITS + 16 + 3*TIME_BITS + TIME_BITS + 4 + 2 - 1:0];
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      best_v_r   <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (act_q[cidx] && (!best_v_r || due_q[cidx] < best_due_r)) begin
        best_v_r   <= 1'b1;
        best_r     <= cidx;
        best_due_r <= due_q[cidx];
      end
      scan_idx_r <= scan_idx_r + 1'b1;
    end
    if (cmd.div_start) begin
      rem_r     <= '0;
      div_cnt_r <= (DW+1)'(TIME_BITS - 1);
    end
    if (cmd.div_step && per_r != '0) begin
      rem_r     <= rem_sub[TIME_BITS] ? rem_sh : rem_sub;
      div_cnt_r <= div_cnt_r - 1'b1;
    end else if (cmd.div_step) begin
      div_cnt_r <= '0;
    end
    if (cmd.mul_step) begin
      thr_r <= (TIME_BITS+9)'(per_q[sidx]) * (TIME_BITS+9)'(marg_r);
    end
  end

  // result bits: fired, slot[4], retired, found, resynced
  logic [RES_BITS-1:0] res_nxt_r;
  always_ff @(posedge clk) begin
    if (cmd.load) res_nxt_r <= '0;
    if (cmd.fire && fdue) res_nxt_r <= {1'b0, 1'b0, !fkeep, 4'(best_r), 1'b1};
    if (cmd.sync) res_nxt_r <= {s_res, s_found, 1'b0, 4'd0, 1'b0};
    if (cmd.modify) res_nxt_r <= {1'b0, m_found, 1'b0, 4'd0, 1'b0};
    if (cmd.out_load) res_r <= res_nxt_r;
  end

  // slot table writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TIMER_SLOTS; i++) act_q[i] <= 1'b0;
    end else begin
      if (cmd.fire && fdue) begin
        last_q[best_r] <= now_r;
        cnt_q[best_r]  <= fcnt;
        due_q[best_r]  <= fsum[TIME_BITS] ? TMAX : fsum[TIME_BITS-1:0];
        if (!fkeep) act_q[best_r] <= 1'b0;
      end
      if (cmd.arm && ok) begin
        act_q[sidx]   <= 1'b1;
        due_q[sidx]   <= st_sum[TIME_BITS] ? TMAX : st_sum[TIME_BITS-1:0];
        stopt_q[sidx] <= stop_r;
        per_q[sidx]   <= per_r;
        lim_q[sidx]   <= lim_r;
        cnt_q[sidx]   <= '0;
        last_q[sidx]  <= '0;
        sen_q[sidx]   <= syn_r;
      end
      if (cmd.sync && s_res) begin
        due_q[sidx] <= ns_sum[TIME_BITS] ? TMAX : ns_sum[TIME_BITS-1:0];
      end
      if (cmd.modify && m_found) begin
        due_q[sidx]   <= m_due;
        stopt_q[sidx] <= m_stop;
        per_q[sidx]   <= m_per;
        act_q[sidx]   <= (m_per != '0) && ((m_stop == '0) || (m_due < m_stop));
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/periodic_timer_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_core: sixteen-slot periodic timer scheduler
// Tick fires the earliest due slot; arm, sync and modify update one slot.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser
//  in_     | in  | fields of one request          | -
//  out_    | out | fired, slot, retired, found,   | -
//          |     | resynced                       |
// Tick: one slot is compared per cycle in the scan.
// Arm: start alignment by the one-bit-per-cycle remainder divider.
// One item at a time; in_tready high only when idle. Reset clears the
// slot active bits, the controller state and out_tvalid only. A stalled
// result lets one more item in, which then waits in ST_OUT until the result is taken.
`default_nettype none
module periodic_timer_scheduler_core #(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // action[1:0] slot[5:2] now[53:6] run_time[101:54] stop_time[149:102]
  // repeat_period[197:150] run_limit[213:198] start_offset[261:214]
  // is_sync[262] late_margin[271:263], zero fill to 280
  input  wire logic [279:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fired[0] fired_slot[4:1] retired[5] found[6] resynced[7]
  output logic [7:0]        out_tdata
);
  import pts_pkg::*;

  cmd_t    cmd;
  status_t sts;

  pts_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .cmd
  );

  pts_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
    .clk, .rst_n, .in_item(in_tdata[IN_BITS-1:0]), .cmd, .sts, .res_r(out_tdata)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/pts_checker.sv =====
// ----------------------------------------------------------------------------
// pts_checker: port-level checks for the periodic timer scheduler
// Watches handshakes and result encoding on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module pts_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // one item in flight: ready drops after each input transaction
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transaction");
  // a fired result never reports found or resynced
  a_enc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[6] && !out_tdata[7])
    else $error("fired with found");
  // retire or slot only with fire
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[5:1] == 5'd0)
    else $error("retired without fire");
endmodule

bind periodic_timer_scheduler_core pts_checker u_pts_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

// ===== tb/periodic_timer_scheduler_core_tb.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_core_tb: self-checking bench for the timer scheduler
// Drives tick, arm, sync and modify transactions with random idle gaps on both
// channels, predicts each result from a private copy of the slot table and
// compares every returned transaction field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class timer_scoreboard;
  localparam int NSLOT = 16;
  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;

  bit          act   [NSLOT];
  logic [47:0] due   [NSLOT];
  logic [47:0] stp   [NSLOT];
  logic [47:0] per   [NSLOT];
  logic [15:0] lim   [NSLOT];
  logic [15:0] cnt   [NSLOT];
  logic [47:0] lastf [NSLOT];
  bit          syn   [NSLOT];
  logic [7:0]  pending_results[$];
  int          errors;
  int          checked;
  int          fires;
  int          resyncs;

  function new();
    foreach (act[i]) act[i] = 0;
    errors = 0;
    checked = 0;
    fires = 0;
    resyncs = 0;
  endfunction

  // saturating add within 48 bits
  function logic [47:0] sat_add(logic [47:0] a, logic [47:0] b, output bit ovf);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    ovf = s[48];
    return s[48] ? TMAX : s[47:0];
  endfunction

  // predict the result of one accepted request
  function void note_request(logic [279:0] d);
    logic [1:0]  a;
    logic [3:0]  s;
    logic [47:0] now, run, stop, pd, off, start, aligned, rem;
    logic [15:0] rl;
    bit          sy, ovf, keep;
    logic [8:0]  mg;
    logic [7:0]  res;
    int          best;
    logic [63:0] late, thr;
    a = d[1:0]; s = d[5:2]; now = d[53:6]; run = d[101:54]; stop = d[149:102];
    pd = d[197:150]; rl = d[213:198]; off = d[261:214]; sy = d[262]; mg = d[271:263];
    res = '0;
    case (a)
      pts_pkg::ACT_TICK: begin
        best = -1;
        for (int i = 0; i < NSLOT; i++)
          if (act[i] && (best < 0 || due[i] < due[best])) best = i;
        if (best >= 0 && due[best] <= now) begin
          res[0] = 1; res[4:1] = best[3:0];
          lastf[best] = now;
          if (cnt[best] != 16'hFFFF) cnt[best]++;
          due[best] = sat_add(due[best], per[best], ovf);
          keep = !ovf && per[best] != 0 && (stp[best] == 0 || due[best] < stp[best])
                 && (lim[best] == 0 || cnt[best] < lim[best]);
          if (!keep) begin
            act[best] = 0; res[5] = 1;
          end
          fires++;
        end
      end
      pts_pkg::ACT_ARM: begin
        if (pd != 0 && now >= run) begin
          rem = now % pd;
          aligned = (rem != 0) ? sat_add(now, pd - rem, ovf) : now;
          start = sat_add(aligned, off, ovf);
        end else start = sat_add(run, off, ovf);
        act[s] = 1; due[s] = start; stp[s] = stop; per[s] = pd; lim[s] = rl;
        cnt[s] = 0; lastf[s] = 0; syn[s] = sy;
      end
      pts_pkg::ACT_SYNC: begin
        if (act[s] && syn[s]) begin
          res[6] = 1;
          if (now >= lastf[s]) begin
            late = 64'(now - lastf[s]);
            // 48-bit period times 9-bit margin fits in 64 bits exactly
            thr = ((64'(per[s]) >> 8) * mg) + (((64'(per[s]) & 64'hFF) * mg) >> 8);
            if (late > thr) begin
              due[s] = sat_add(now, per[s], ovf);
              res[7] = 1; resyncs++;
            end
          end
        end
      end
      default: begin
        if (act[s]) begin
          res[6] = 1;
          if (run != 0) due[s] = run;
          if (stop != 0) stp[s] = stop;
          if (pd != 0) per[s] = pd;
          act[s] = per[s] != 0 && (stp[s] == 0 || due[s] < stp[s]);
        end
      end
    endcase
    pending_results.push_back(res);
  endfunction

  // compare one returned result with the oldest prediction
  function void check_result(logic [7:0] got);
    logic [7:0] exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    checked++;
    if (got[0] !== exp_r[0]) begin
      $display("%0t: fired exp %b got %b", $time, exp_r[0], got[0]); errors++;
    end
    if (got[4:1] !== exp_r[4:1]) begin
      $display("%0t: fired_slot exp %0d got %0d", $time, exp_r[4:1], got[4:1]); errors++;
    end
    if (got[5] !== exp_r[5]) begin
      $display("%0t: retired exp %b got %b", $time, exp_r[5], got[5]); errors++;
    end
    if (got[6] !== exp_r[6]) begin
      $display("%0t: found exp %b got %b", $time, exp_r[6], got[6]); errors++;
    end
    if (got[7] !== exp_r[7]) begin
      $display("%0t: resynced exp %b got %b", $time, exp_r[7], got[7]); errors++;
    end
  endfunction
endclass

module periodic_timer_scheduler_core_tb;
  import pts_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // action, slot, now, run_time, stop_time, repeat_period, run_limit,
  // start_offset, is_sync, late_margin, zero fill
  logic [279:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // fired, fired_slot, retired, found, resynced
  logic [7:0]   out_tdata;

  timer_scoreboard sb;
  logic [47:0] clock_now;
  bit          send_done;

  periodic_timer_scheduler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // random time: mostly small, sometimes anywhere in the 48-bit range
  function automatic logic [47:0] rand_time(int unsigned small_max);
    case ($urandom_range(0, 9))
      0: return 48'({$urandom(), $urandom()});
      1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 50));
      default: return 48'($urandom_range(0, small_max));
    endcase
  endfunction

  // send one request after a random gap; valid stays up when there is no gap
  task automatic send_request(action_t a, logic [3:0] s, logic [47:0] now,
                              logic [47:0] run, logic [47:0] stop, logic [47:0] pd,
                              logic [15:0] rl, logic [47:0] off, bit sy, logic [8:0] mg);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {8'h0, mg, sy, off, rl, pd, stop, run, now, s, a};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request({8'h0, mg, sy, off, rl, pd, stop, run, now, s, a});
  endtask

  // one random request on a monotone-ish clock
  task automatic random_request();
    action_t a;
    logic [47:0] p;
    int r;
    r = $urandom_range(0, 99);
    a = (r < 50) ? ACT_TICK : (r < 72) ? ACT_ARM : (r < 86) ? ACT_SYNC : ACT_MODIFY;
    if ($urandom_range(0, 30) == 0) clock_now = rand_time(32'hFFFF_FFFF);
    else clock_now = clock_now + $urandom_range(0, 40);
    p = ($urandom_range(0, 7) == 0) ? rand_time(1000) : 48'($urandom_range(0, 60));
    send_request(a, 4'($urandom()),
      ($urandom_range(0, 15) == 0) ? rand_time(1000) : clock_now,
      ($urandom_range(0, 3) == 0) ? 48'h0 :
        (($urandom_range(0, 7) == 0) ? rand_time(1000) : clock_now + $urandom_range(0, 80)),
      ($urandom_range(0, 2) == 0) ? 48'h0 :
        (($urandom_range(0, 7) == 0) ? rand_time(1000) : clock_now + $urandom_range(0, 600)),
      p,
      ($urandom_range(0, 2) == 0) ? 16'h0 :
        (($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 8))),
      ($urandom_range(0, 3) == 0) ? rand_time(100) : 48'h0,
      1'($urandom()), 9'($urandom_range(0, 511)));
  endtask

  // stimulus
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    clock_now = 48'd100;
    send_done = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty table, extremes, retire causes, sync and modify cases
    send_request(ACT_TICK, 4'd0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SYNC, 4'd3, 48'd5, 0, 0, 0, 0, 0, 1, 9'd0);
    send_request(ACT_MODIFY, 4'd3, 48'd5, 48'd1, 0, 0, 0, 0, 0, 0);
    send_request(ACT_ARM, 4'd15, 48'd105, 48'd10, 48'd0, 48'd10, 16'd0, 48'd3, 1, 9'd256);
    send_request(ACT_ARM, 4'd0, 48'd0, 48'd50, 48'd0, 48'd0, 16'd0, 48'd0, 0, 9'd0);
    send_request(ACT_ARM, 4'd1, 48'd0, 48'd50, 48'd70, 48'd10, 16'd2, 48'd0, 1, 9'd511);
    send_request(ACT_TICK, 4'd0, 48'd49, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_TICK, 4'd0, 48'd50, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_TICK, 4'd0, 48'd60, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_TICK, 4'd0, 48'd200, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_TICK, 4'd0, 48'd200, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SYNC, 4'd15, 48'd400, 0, 0, 0, 0, 0, 0, 9'd0);
    send_request(ACT_SYNC, 4'd15, 48'd111, 0, 0, 0, 0, 0, 0, 9'd256);
    send_request(ACT_ARM, 4'd7, 48'hFFFF_FFFF_FFF0, 48'd0, 48'd0, 48'hFFFF_FFFF_FFFF,
                 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1, 9'd1);
    send_request(ACT_TICK, 4'd0, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_ARM, 4'd9, 48'd0, 48'd1000, 48'd0, 48'd100, 16'd0, 48'd0, 1, 9'd0);
    send_request(ACT_MODIFY, 4'd9, 48'd0, 48'd0, 48'd0, 48'd0, 0, 0, 0, 0);
    send_request(ACT_MODIFY, 4'd9, 48'd0, 48'd900, 48'd800, 48'd0, 0, 0, 0, 0);
    send_request(ACT_ARM, 4'd9, 48'd0, 48'd1000, 48'd0, 48'd100, 16'd0, 48'd0, 1, 9'd0);
    send_request(ACT_MODIFY, 4'd9, 48'd0, 48'd0, 48'd5000, 48'd7, 0, 0, 0, 0);
    send_request(ACT_TICK, 4'd0, 48'd2000, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SYNC, 4'd9, 48'd3000, 0, 0, 0, 0, 0, 0, 9'd0);
    send_request(ACT_SYNC, 4'd9, 48'd1, 0, 0, 0, 0, 0, 0, 9'd0);
    // random part
    repeat (800) random_request();
    in_tvalid <= 1'b0;
    send_done = 1;
  end

  // result sink with random stalls; ready stays up when there is no stall
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
    end
  end

  // end of run
  initial begin
    @(posedge clk);
    wait (send_done);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d results: %0d firings, %0d resyncs.", sb.checked, sb.fires,
             sb.resyncs);
    if (sb.errors == 0 && sb.pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // timeout
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

`default_nettype wire
